### hdl/dta_pkg.sv
// shared constants, register map and configuration type of the differential thrust allocator
package dta_pkg;

   // field widths
   localparam int IN_W       = 24;
   localparam int THRUST_W   = 23;
   localparam int COEF_W     = 24;
   localparam int CMD_W      = 16;
   localparam int FORCE_W    = 25;
   localparam int TORQUE_W   = 32;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_FWD           = 3'd0,
      CSR_MAX_BWD           = 3'd1,
      CSR_HALF_SPACING      = 3'd2,
      CSR_INV_TWICE_SPACING = 3'd3,
      CSR_FWD_GAIN          = 3'd4,
      CSR_BWD_GAIN          = 3'd5
   } dta_csr_index_type;

   // reset values: limits 1.0 (Q12.12), reciprocal 0.5 and gains 1.0 (Q4.20)
   localparam logic [THRUST_W-1:0] RST_MAX_FWD           = 23'd4096;
   localparam logic [THRUST_W-1:0] RST_MAX_BWD           = 23'd4096;
   localparam logic [THRUST_W-1:0] RST_HALF_SPACING      = 23'd4096;
   localparam logic [COEF_W-1:0]   RST_INV_TWICE_SPACING = 24'd524288;
   localparam logic [COEF_W-1:0]   RST_FWD_GAIN          = 24'd1048576;
   localparam logic [COEF_W-1:0]   RST_BWD_GAIN          = 24'd1048576;

   // register contents as seen by the datapath
   typedef struct packed {
      logic [THRUST_W-1:0] max_fwd;
      logic [THRUST_W-1:0] max_bwd;
      logic [THRUST_W-1:0] half_spacing;
      logic [COEF_W-1:0]   inv_twice_spacing;
      logic [COEF_W-1:0]   fwd_gain;
      logic [COEF_W-1:0]   bwd_gain;
   } dta_cfg_type;

endpackage

### hdl/dta_if.sv
// request and response channel interfaces of the differential thrust allocator

// request channel: surge force and yaw torque
interface dta_req_if;
   import dta_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [IN_W-1:0]  surge_force;
   logic signed [IN_W-1:0]  yaw_torque;

   modport source (output valid, output surge_force, output yaw_torque, input ready);
   modport sink   (input valid, input surge_force, input yaw_torque, output ready);
endinterface

// response channel: thruster commands and effective force and torque
interface dta_rsp_if;
   import dta_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [CMD_W-1:0]     left_command;
   logic signed [CMD_W-1:0]     right_command;
   logic signed [FORCE_W-1:0]   effective_force;
   logic signed [TORQUE_W-1:0]  effective_torque;

   modport source (output valid, output left_command, output right_command,
                   output effective_force, output effective_torque, input ready);
   modport sink   (input valid, input left_command, input right_command,
                   input effective_force, input effective_torque, output ready);
endinterface

### hdl/dta_csr.sv
// configuration registers of the differential thrust allocator
module dta_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [dta_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dta_pkg::CSR_DATA_W-1:0] csr_wdata,
   output dta_pkg::dta_cfg_type           cfg
);
   import dta_pkg::*;

   dta_cfg_type cfg_ff;
   dta_cfg_type cfg_in;

   // register write decode, unknown indexes leave everything unchanged
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (dta_csr_index_type'(csr_index))
            CSR_MAX_FWD:           cfg_in.max_fwd           = csr_wdata[THRUST_W-1:0];
            CSR_MAX_BWD:           cfg_in.max_bwd           = csr_wdata[THRUST_W-1:0];
            CSR_HALF_SPACING:      cfg_in.half_spacing      = csr_wdata[THRUST_W-1:0];
            CSR_INV_TWICE_SPACING: cfg_in.inv_twice_spacing = csr_wdata[COEF_W-1:0];
            CSR_FWD_GAIN:          cfg_in.fwd_gain          = csr_wdata[COEF_W-1:0];
            CSR_BWD_GAIN:          cfg_in.bwd_gain          = csr_wdata[COEF_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   // register bank
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_fwd           <= RST_MAX_FWD;
         cfg_ff.max_bwd           <= RST_MAX_BWD;
         cfg_ff.half_spacing      <= RST_HALF_SPACING;
         cfg_ff.inv_twice_spacing <= RST_INV_TWICE_SPACING;
         cfg_ff.fwd_gain          <= RST_FWD_GAIN;
         cfg_ff.bwd_gain          <= RST_BWD_GAIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hdl/dta_pipe.sv
// eight-stage allocation pipeline: torque clamp, split, surge limit, thrust clamp, commands
module dta_pipe (
   input  logic                 clock,
   input  logic                 reset,
   input  dta_pkg::dta_cfg_type cfg,
   dta_req_if.sink              req,
   dta_rsp_if.source            rsp
);
   import dta_pkg::*;

   localparam int NUM_STAGES = 8;
   localparam int BW_W       = 2 * THRUST_W;         // max_bwd * half_spacing
   localparam int TZLIM_W    = BW_W - 11;            // (b * w * 2) >> 12
   localparam int CLAMP_W    = TZLIM_W + 1;
   localparam int TPROD_W    = IN_W + COEF_W;        // torque times reciprocal
   localparam int SHARE_MAG_W = TPROD_W - 20;
   localparam int SHARE_W    = SHARE_MAG_W + 1;
   localparam int LIM_W      = 32;
   localparam int T2_W       = THRUST_W + 2;         // thrust at twice its value
   localparam int SUM_W      = T2_W + 1;
   localparam int MUL_W      = 49;
   localparam logic [TPROD_W-1:0] SHARE_HALF  = TPROD_W'(1) << 19;
   localparam logic [MUL_W-1:0]   CMD_HALF    = MUL_W'(1) << 18;
   localparam logic [MUL_W-1:0]   TORQUE_HALF = MUL_W'(1) << 12;
   localparam int CMD_MAG_W    = MUL_W - 19;
   localparam int TORQUE_MAG_W = MUL_W - 13;

   // stage valids and load enables
   logic [NUM_STAGES:1] vld_ff;
   logic [NUM_STAGES:1] vld_in;
   logic [NUM_STAGES:1] adv;

   // stage payload registers
   logic signed [IN_W-1:0]     s1_fx_ff, s1_tz_ff;
   logic        [BW_W-1:0]     s1_bw_ff, s1_bw_in;
   logic signed [IN_W-1:0]     s2_fx_ff, s2_tz_ff, s2_tz_in;
   logic signed [IN_W-1:0]     s3_fx_ff;
   logic                       s3_tzneg_ff;
   logic signed [TPROD_W-1:0]  s3_prod_ff, s3_prod_in;
   logic signed [IN_W-1:0]     s4_fx_ff;
   logic                       s4_tzneg_ff;
   logic signed [SHARE_W-1:0]  s4_share_ff, s4_share_in;
   logic signed [LIM_W-1:0]    s5_fx_ff, s5_fx_in;
   logic signed [SHARE_W-1:0]  s5_share_ff;
   logic signed [T2_W-1:0]     s6_l2_ff, s6_l2_in, s6_r2_ff, s6_r2_in;
   logic signed [FORCE_W-1:0]  s7_force_ff, s7_force_in;
   logic signed [MUL_W-1:0]    s7_pl_ff, s7_pl_in, s7_pr_ff, s7_pr_in, s7_pt_ff, s7_pt_in;
   logic signed [CMD_W-1:0]    s8_lcmd_ff, s8_lcmd_in, s8_rcmd_ff, s8_rcmd_in;
   logic signed [FORCE_W-1:0]  s8_force_ff;
   logic signed [TORQUE_W-1:0] s8_torque_ff, s8_torque_in;

   // working signals
   logic        [TZLIM_W-1:0]     tz_lim;
   logic signed [CLAMP_W-1:0]     tz_wide, tz_lim_s, tz_clamped;
   logic        [TPROD_W-1:0]     prod_mag, prod_rnd;
   logic        [SHARE_MAG_W-1:0] share_mag;
   logic                          fx_neg;
   logic signed [LIM_W-1:0]       lim_base, lim_term, surge_lim, fx_wide;
   logic signed [LIM_W-1:0]       share2, l2_raw, r2_raw, t2_hi, t2_lo;
   logic signed [SUM_W-1:0]       t2_sum, t2_diff;
   logic        [SUM_W-1:0]       sum_mag, sum_rnd;
   logic        [FORCE_W-1:0]     force_mag;
   logic        [COEF_W-1:0]      gain_l, gain_r;

   // round a command product to Q2.14, halves away from zero, and saturate
   function automatic logic [CMD_W-1:0] cmd_round(input logic signed [MUL_W-1:0] p);
      logic [MUL_W-1:0]     mag;
      logic [MUL_W-1:0]     rnd;
      logic [CMD_MAG_W-1:0] r;
      mag = p[MUL_W-1] ? MUL_W'(-p) : MUL_W'(p);
      rnd = mag + CMD_HALF;
      r   = rnd[MUL_W-1:19];
      if (!p[MUL_W-1]) begin
         cmd_round = (r > CMD_MAG_W'((1 << (CMD_W-1)) - 1)) ?
                     {1'b0, {(CMD_W-1){1'b1}}} : r[CMD_W-1:0];
      end else begin
         cmd_round = (r > CMD_MAG_W'(1 << (CMD_W-1))) ?
                     {1'b1, {(CMD_W-1){1'b0}}} : CMD_W'(0) - r[CMD_W-1:0];
      end
   endfunction

   // round the torque product to Q12.12, halves away from zero, and saturate
   function automatic logic [TORQUE_W-1:0] torque_round(input logic signed [MUL_W-1:0] p);
      logic [MUL_W-1:0]        mag;
      logic [MUL_W-1:0]        rnd;
      logic [TORQUE_MAG_W-1:0] r;
      mag = p[MUL_W-1] ? MUL_W'(-p) : MUL_W'(p);
      rnd = mag + TORQUE_HALF;
      r   = rnd[MUL_W-1:13];
      if (!p[MUL_W-1]) begin
         torque_round = (r > TORQUE_MAG_W'((64'd1 << (TORQUE_W-1)) - 64'd1)) ?
                        {1'b0, {(TORQUE_W-1){1'b1}}} : r[TORQUE_W-1:0];
      end else begin
         torque_round = (r > TORQUE_MAG_W'(64'd1 << (TORQUE_W-1))) ?
                        {1'b1, {(TORQUE_W-1){1'b0}}} : TORQUE_W'(0) - r[TORQUE_W-1:0];
      end
   endfunction

   // flow control: a stage loads when it is empty or its successor moves on
   always_comb begin
      adv[NUM_STAGES] = !vld_ff[NUM_STAGES] || rsp.ready;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign vld_in    = {vld_ff[NUM_STAGES-1:1], req.valid};
   assign req.ready = adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // stage 1: capture request, torque limit product
   assign s1_bw_in = cfg.max_bwd * cfg.half_spacing;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s1_fx_ff <= req.surge_force;
         s1_tz_ff <= req.yaw_torque;
         s1_bw_ff <= s1_bw_in;
      end
   end

   // stage 2: clamp torque to what full reverse thrust allows
   always_comb begin
      tz_lim   = s1_bw_ff[BW_W-1:11];
      tz_wide  = CLAMP_W'(s1_tz_ff);
      tz_lim_s = $signed({1'b0, tz_lim});
      if (tz_wide > tz_lim_s) begin
         tz_clamped = tz_lim_s;
      end else if (tz_wide < -tz_lim_s) begin
         tz_clamped = -tz_lim_s;
      end else begin
         tz_clamped = tz_wide;
      end
      s2_tz_in = tz_clamped[IN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s2_fx_ff <= s1_fx_ff;
         s2_tz_ff <= s2_tz_in;
      end
   end

   // stage 3: torque times reciprocal of twice the lever arm
   assign s3_prod_in = s2_tz_ff * $signed({1'b0, cfg.inv_twice_spacing});

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s3_fx_ff    <= s2_fx_ff;
         s3_tzneg_ff <= s2_tz_ff[IN_W-1];
         s3_prod_ff  <= s3_prod_in;
      end
   end

   // stage 4: round the split symmetrically
   always_comb begin
      prod_mag    = s3_prod_ff[TPROD_W-1] ? TPROD_W'(-s3_prod_ff) : TPROD_W'(s3_prod_ff);
      prod_rnd    = prod_mag + SHARE_HALF;
      share_mag   = prod_rnd[TPROD_W-1:20];
      s4_share_in = s3_prod_ff[TPROD_W-1] ? -$signed({1'b0, share_mag})
                                          : $signed({1'b0, share_mag});
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s4_fx_ff    <= s3_fx_ff;
         s4_tzneg_ff <= s3_tzneg_ff;
         s4_share_ff <= s4_share_in;
      end
   end

   // stage 5: limit surge by the thruster that saturates first
   always_comb begin
      fx_neg    = s4_fx_ff[IN_W-1];
      fx_wide   = LIM_W'(s4_fx_ff);
      lim_base  = fx_neg ? -$signed({{(LIM_W-THRUST_W){1'b0}}, cfg.max_bwd})
                         : $signed({{(LIM_W-THRUST_W){1'b0}}, cfg.max_fwd});
      lim_term  = (s4_tzneg_ff == fx_neg) ? -LIM_W'(s4_share_ff) : LIM_W'(s4_share_ff);
      surge_lim = (lim_base + lim_term) <<< 1;
      if (fx_neg) begin
         s5_fx_in = (fx_wide < surge_lim) ? surge_lim : fx_wide;
      end else begin
         s5_fx_in = (fx_wide > surge_lim) ? surge_lim : fx_wide;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s5_fx_ff    <= s5_fx_in;
         s5_share_ff <= s4_share_ff;
      end
   end

   // stage 6: double-scale thrusts, clamped to the forward and reverse limits
   always_comb begin
      share2 = LIM_W'(s5_share_ff) <<< 1;
      l2_raw = s5_fx_ff + share2;
      r2_raw = s5_fx_ff - share2;
      t2_hi  = $signed({{(LIM_W-THRUST_W-1){1'b0}}, cfg.max_fwd, 1'b0});
      t2_lo  = -$signed({{(LIM_W-THRUST_W-1){1'b0}}, cfg.max_bwd, 1'b0});
      if (l2_raw > t2_hi) begin
         s6_l2_in = t2_hi[T2_W-1:0];
      end else if (l2_raw < t2_lo) begin
         s6_l2_in = t2_lo[T2_W-1:0];
      end else begin
         s6_l2_in = l2_raw[T2_W-1:0];
      end
      if (r2_raw > t2_hi) begin
         s6_r2_in = t2_hi[T2_W-1:0];
      end else if (r2_raw < t2_lo) begin
         s6_r2_in = t2_lo[T2_W-1:0];
      end else begin
         s6_r2_in = r2_raw[T2_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         s6_l2_ff <= s6_l2_in;
         s6_r2_ff <= s6_r2_in;
      end
   end

   // stage 7: effective force, torque and command products
   always_comb begin
      t2_sum      = SUM_W'(s6_l2_ff) + SUM_W'(s6_r2_ff);
      t2_diff     = SUM_W'(s6_l2_ff) - SUM_W'(s6_r2_ff);
      sum_mag     = t2_sum[SUM_W-1] ? SUM_W'(-t2_sum) : SUM_W'(t2_sum);
      sum_rnd     = sum_mag + SUM_W'(1);
      force_mag   = sum_rnd[SUM_W-1:1];
      s7_force_in = t2_sum[SUM_W-1] ? FORCE_W'(0) - force_mag : force_mag;
      s7_pt_in    = t2_diff * $signed({1'b0, cfg.half_spacing});
      gain_l      = s6_l2_ff[T2_W-1] ? cfg.bwd_gain : cfg.fwd_gain;
      gain_r      = s6_r2_ff[T2_W-1] ? cfg.bwd_gain : cfg.fwd_gain;
      s7_pl_in    = s6_l2_ff * $signed({1'b0, gain_l});
      s7_pr_in    = s6_r2_ff * $signed({1'b0, gain_r});
   end

   always_ff @(posedge clock) begin
      if (adv[7]) begin
         s7_force_ff <= s7_force_in;
         s7_pt_ff    <= s7_pt_in;
         s7_pl_ff    <= s7_pl_in;
         s7_pr_ff    <= s7_pr_in;
      end
   end

   // stage 8: rounding and saturation into the output register
   assign s8_lcmd_in   = cmd_round(s7_pl_ff);
   assign s8_rcmd_in   = cmd_round(s7_pr_ff);
   assign s8_torque_in = torque_round(s7_pt_ff);

   always_ff @(posedge clock) begin
      if (adv[8]) begin
         s8_lcmd_ff   <= s8_lcmd_in;
         s8_rcmd_ff   <= s8_rcmd_in;
         s8_force_ff  <= s7_force_ff;
         s8_torque_ff <= s8_torque_in;
      end
   end

   // response drive
   assign rsp.valid            = vld_ff[NUM_STAGES];
   assign rsp.left_command     = s8_lcmd_ff;
   assign rsp.right_command    = s8_rcmd_ff;
   assign rsp.effective_force  = s8_force_ff;
   assign rsp.effective_torque = s8_torque_ff;

   // checks
   a_left_in_limits: assert property (@(posedge clock) disable iff (reset)
      vld_ff[6] |-> (LIM_W'(s6_l2_ff) <= t2_hi) && (LIM_W'(s6_l2_ff) >= t2_lo))
      else $error("left thrust outside its limits");

   a_right_in_limits: assert property (@(posedge clock) disable iff (reset)
      vld_ff[6] |-> (LIM_W'(s6_r2_ff) <= t2_hi) && (LIM_W'(s6_r2_ff) >= t2_lo))
      else $error("right thrust outside its limits");

   a_share_follows_torque: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> !(s4_tzneg_ff && (s4_share_ff > 0)) &&
                    !(!s4_tzneg_ff && (s4_share_ff < 0)))
      else $error("thrust split opposes the torque sign");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("response valid right after reset");

endmodule

### hdl/differential_thrust_allocator_top.sv
// top level of the differential thrust allocator: registers and allocation pipeline
// The allocator turns a surge force and yaw torque request (signed Q12.12) into left and
// right thruster commands (Q2.14) plus the effective force and torque, with yaw taking
// priority over surge. It accepts one request per clock while the pipeline has room and returns
// each response through the eight-stage pipeline from request capture to the output register,
// and stages whose result is not yet taken keep empty slots filling so a
// stalled response does not stop requests while room remains. Registers are written through
// the csr port and must only change while no request is in flight.
module differential_thrust_allocator_top (
   input  logic                           clock,
   input  logic                           reset,
   dta_req_if.sink                        req_chan,
   dta_rsp_if.source                      rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [dta_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dta_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dta_pkg::*;

   dta_cfg_type cfg;

   // configuration registers
   dta_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // allocation pipeline
   dta_pipe u_pipe (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_chan),
      .rsp   (rsp_chan)
   );

endmodule

### tb/tb_differential_thrust_allocator_top.sv
// self-checking testbench of the differential thrust allocator top level
`timescale 1ns / 100ps

module tb_differential_thrust_allocator_top;
   import dta_pkg::*;

   // input extremes and the two register indexes beyond the map
   localparam logic signed [IN_W-1:0]      IN_MAX = 24'sh7F_FFFF;
   localparam logic signed [IN_W-1:0]      IN_MIN = 24'sh80_0000;
   localparam logic [CSR_IDX_W-1:0]        CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0]        CSR_SPARE_HI = 3'd7;
   localparam longint                      TORQUE_MAX = (64'sd1 <<< 31) - 1;
   localparam longint                      TORQUE_MIN = -(64'sd1 <<< 31);
   localparam int                          RANDOM_PHASES = 9;
   localparam int                          PHASE_REQUESTS = 150;
   localparam int                          HOLD_CYCLES = 300;
   localparam int                          DRAIN_CYCLES = 16;

   typedef struct {
      logic signed [CMD_W-1:0]    left_cmd;
      logic signed [CMD_W-1:0]    right_cmd;
      logic signed [FORCE_W-1:0]  sum_force;
      logic signed [TORQUE_W-1:0] sum_torque;
   } thrust_result_type;

   // allocation predictor and queue of expected responses
   class thrust_scoreboard;
      dta_cfg_type         cfg;
      thrust_result_type   pending[$];
      int                  checked;
      int                  mismatches;

      function new();
         cfg = '{RST_MAX_FWD, RST_MAX_BWD, RST_HALF_SPACING,
                 RST_INV_TWICE_SPACING, RST_FWD_GAIN, RST_BWD_GAIN};
         checked = 0;
         mismatches = 0;
      endfunction

      // register write as the block sees it: masked, spare indexes dropped
      function void apply_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_MAX_FWD:           cfg.max_fwd = data[THRUST_W-1:0];
            CSR_MAX_BWD:           cfg.max_bwd = data[THRUST_W-1:0];
            CSR_HALF_SPACING:      cfg.half_spacing = data[THRUST_W-1:0];
            CSR_INV_TWICE_SPACING: cfg.inv_twice_spacing = data[COEF_W-1:0];
            CSR_FWD_GAIN:          cfg.fwd_gain = data[COEF_W-1:0];
            CSR_BWD_GAIN:          cfg.bwd_gain = data[COEF_W-1:0];
            default: ;
         endcase
      endfunction

      // divide by 2^s, nearest, halves away from zero
      function longint round_shift(longint x, int s);
         longint m;
         longint r;
         m = (x < 0) ? -x : x;
         r = (m + (64'sd1 <<< (s - 1))) >>> s;
         return (x < 0) ? -r : r;
      endfunction

      function longint clamp_to(longint x, longint lo, longint hi);
         if (x < lo) return lo;
         if (x > hi) return hi;
         return x;
      endfunction

      // doubled thrust to saturated command, gain picked by direction
      function logic signed [CMD_W-1:0] thrust_command(longint thrust2);
         longint fwd_gain;
         longint bwd_gain;
         longint c;
         fwd_gain = cfg.fwd_gain;
         bwd_gain = cfg.bwd_gain;
         if (thrust2 > 0)
            c = round_shift(thrust2 * fwd_gain, 19);
         else if (thrust2 < 0)
            c = round_shift(thrust2 * bwd_gain, 19);
         else
            c = 0;
         c = clamp_to(c, -32768, 32767);
         return c[CMD_W-1:0];
      endfunction

      function longint yaw_limit();
         longint bwd;
         longint arm;
         bwd = cfg.max_bwd;
         arm = cfg.half_spacing;
         return (bwd * arm * 2) >>> 12;
      endfunction

      // yaw first, then surge limited by the limiting thruster
      function thrust_result_type allocate(logic signed [IN_W-1:0] surge,
                                           logic signed [IN_W-1:0] yaw);
         thrust_result_type res;
         longint surge_q, yaw_q, fwd, bwd, arm, inv, lim, share;
         longint left2, right2, sum_f, sum_t;
         surge_q = surge;
         yaw_q = yaw;
         fwd = cfg.max_fwd;
         bwd = cfg.max_bwd;
         arm = cfg.half_spacing;
         inv = cfg.inv_twice_spacing;
         lim = yaw_limit();
         yaw_q = clamp_to(yaw_q, -lim, lim);
         share = round_shift(yaw_q * inv, 20);
         // four sign cases pick the thruster that limits the surge
         if (yaw_q >= 0) begin
            if (surge_q >= 0) begin
               lim = (fwd - share) * 2;
               if (surge_q > lim) surge_q = lim;
            end else begin
               lim = (-bwd + share) * 2;
               if (surge_q < lim) surge_q = lim;
            end
         end else begin
            if (surge_q >= 0) begin
               lim = (fwd + share) * 2;
               if (surge_q > lim) surge_q = lim;
            end else begin
               lim = (-bwd - share) * 2;
               if (surge_q < lim) surge_q = lim;
            end
         end
         left2 = clamp_to(2 * share + surge_q, -2 * bwd, 2 * fwd);
         right2 = clamp_to(-2 * share + surge_q, -2 * bwd, 2 * fwd);
         sum_f = round_shift(left2 + right2, 1);
         sum_t = clamp_to(round_shift((left2 - right2) * arm, 13), TORQUE_MIN, TORQUE_MAX);
         res.left_cmd = thrust_command(left2);
         res.right_cmd = thrust_command(right2);
         res.sum_force = sum_f[FORCE_W-1:0];
         res.sum_torque = sum_t[TORQUE_W-1:0];
         return res;
      endfunction

      function void note_request(logic signed [IN_W-1:0] surge, logic signed [IN_W-1:0] yaw);
         pending.push_back(allocate(surge, yaw));
      endfunction

      task report_mismatch(string what, longint got, longint want);
         $display("response %0d: %s got %0d, expected %0d", checked, what, got, want);
         mismatches++;
      endtask

      task check_response(logic signed [CMD_W-1:0] left_cmd,
                          logic signed [CMD_W-1:0] right_cmd,
                          logic signed [FORCE_W-1:0] sum_force,
                          logic signed [TORQUE_W-1:0] sum_torque);
         thrust_result_type want;
         if (pending.size() == 0) begin
            report_mismatch("unrequested response", 1, 0);
         end else begin
            want = pending.pop_front();
            if (left_cmd !== want.left_cmd)
               report_mismatch("left_command", left_cmd, want.left_cmd);
            if (right_cmd !== want.right_cmd)
               report_mismatch("right_command", right_cmd, want.right_cmd);
            if (sum_force !== want.sum_force)
               report_mismatch("effective_force", sum_force, want.sum_force);
            if (sum_torque !== want.sum_torque)
               report_mismatch("effective_torque", sum_torque, want.sum_torque);
         end
         checked++;
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_wr_en;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_wdata;
   int                        send_idle_pct;
   int                        recv_idle_pct;
   bit                        hold_pending;
   bit                        hold_started = 1'b0;
   int                        hold_left = 0;
   int                        requests_sent;
   int                        settings_used;
   thrust_scoreboard          sb = new();

   dta_req_if req_if ();
   dta_rsp_if rsp_if ();

   differential_thrust_allocator_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // response side: check, then random stalls or a long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.left_command, rsp_if.right_command,
                              rsp_if.effective_force, rsp_if.effective_torque);
         if (hold_pending && !hold_started) begin
            hold_started = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // one request, with random idle cycles ahead of it
   task automatic send_request(input logic signed [IN_W-1:0] surge,
                               input logic signed [IN_W-1:0] yaw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.surge_force <= surge;
      req_if.yaw_torque <= yaw;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_request(surge, yaw);
      requests_sent++;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.apply_write(idx, data);
   endtask

   // whole register set, junk in the unused top bit and in the spare indexes
   task automatic load_settings(input dta_cfg_type c);
      write_register(CSR_SPARE_LO, CSR_DATA_W'($urandom));
      write_register(CSR_MAX_FWD, {1'($urandom_range(1)), c.max_fwd});
      write_register(CSR_MAX_BWD, {1'($urandom_range(1)), c.max_bwd});
      write_register(CSR_HALF_SPACING, {1'($urandom_range(1)), c.half_spacing});
      write_register(CSR_INV_TWICE_SPACING, c.inv_twice_spacing);
      write_register(CSR_FWD_GAIN, c.fwd_gain);
      write_register(CSR_BWD_GAIN, c.bwd_gain);
      write_register(CSR_SPARE_HI, CSR_DATA_W'($urandom));
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   task automatic wait_drained();
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [THRUST_W-1:0] random_thrust();
      case ($urandom_range(3))
         0:       return THRUST_W'($urandom_range(1 << 16));
         1:       return THRUST_W'($urandom_range(1 << 20));
         2:       return THRUST_W'($urandom);
         default: return THRUST_W'($urandom_range(64));
      endcase
   endfunction

   // coefficient that matches 2^bits / divisor, or plain random
   function automatic logic [COEF_W-1:0] random_coef(longint divisor, int bits);
      longint q;
      if ($urandom_range(3) == 0 || divisor == 0)
         return COEF_W'($urandom);
      q = (64'sd1 <<< bits) / divisor;
      if (q > (64'sd1 <<< COEF_W) - 1)
         q = (64'sd1 <<< COEF_W) - 1;
      return q[COEF_W-1:0];
   endfunction

   function automatic dta_cfg_type random_settings();
      dta_cfg_type c;
      c.max_fwd = random_thrust();
      c.max_bwd = random_thrust();
      c.half_spacing = random_thrust();
      c.inv_twice_spacing = random_coef(c.half_spacing, 31);
      c.fwd_gain = random_coef(c.max_fwd, 32);
      c.bwd_gain = random_coef(c.max_bwd, 32);
      return c;
   endfunction

   // input value around a scale, near zero, an extreme, or fully random
   function automatic logic signed [IN_W-1:0] pick_input(longint scale);
      longint s;
      longint v;
      s = (scale > (64'sd1 <<< 23)) ? (64'sd1 <<< 23) : scale;
      case ($urandom_range(4))
         0: v = longint'(IN_W'($urandom)) - (64'sd1 <<< 23);
         1: v = longint'($urandom_range(32'(4 * s))) - 2 * s;
         2: begin
            case ($urandom_range(4))
               0:       v = IN_MAX;
               1:       v = IN_MIN;
               2:       v = 0;
               3:       v = 1;
               default: v = -1;
            endcase
         end
         3: v = ($urandom_range(1) ? s : -s) + longint'($urandom_range(8)) - 4;
         default: v = longint'($urandom_range(16)) - 8;
      endcase
      if (v > IN_MAX) v = IN_MAX;
      if (v < IN_MIN) v = IN_MIN;
      return v[IN_W-1:0];
   endfunction

   // run limit
   initial begin
      #2_000_000;
      $display("differential_thrust_allocator_top verification failed");
      $finish;
   end

   initial begin
      dta_cfg_type c;
      longint      surge_scale;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.surge_force = '0;
      req_if.yaw_torque = '0;
      hold_pending = 1'b0;
      requests_sent = 0;
      settings_used = 1;
      send_idle_pct = 22;
      recv_idle_pct = 78;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: field extremes, zero thrust, rounding near the limits
      send_request(0, 0);
      send_request(IN_MAX, 0);
      send_request(IN_MIN, 0);
      send_request(0, IN_MAX);
      send_request(0, IN_MIN);
      send_request(IN_MAX, IN_MAX);
      send_request(IN_MIN, IN_MIN);
      send_request(IN_MAX, IN_MIN);
      send_request(IN_MIN, IN_MAX);
      send_request(4096, 0);
      send_request(-4096, 2048);
      send_request(1, -1);
      send_request(2048, 8192);
      send_request(-1, 4095);
      req_if.valid <= 1'b0;
      wait_drained();

      // oversized reciprocal reverses the surge; zero reverse gain
      c = sb.cfg;
      c.inv_twice_spacing = 24'd3 << 20;
      c.bwd_gain = '0;
      load_settings(c);
      send_request(1000, 4096);
      send_request(-1000, -4096);
      send_request(4096, -4096);
      send_request(-4096, 4096);
      send_request(0, 8192);
      send_request(IN_MAX, 2048);
      send_request(IN_MIN, -2048);
      send_request(0, 1);
      req_if.valid <= 1'b0;

      // random phases: idling pattern changes every three
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drained();
         if (p < 3) begin
            send_idle_pct = 22;
            recv_idle_pct = 78;
         end else if (p < 6) begin
            send_idle_pct = 78;
            recv_idle_pct = 22;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (p == 0)
            c = '0;
         else if (p == 4)
            c = '1;
         else
            c = random_settings();
         load_settings(c);
         // long response stall while requests keep coming
         if (p == 6)
            hold_pending = 1'b1;
         surge_scale = longint'(sb.cfg.max_fwd) + longint'(sb.cfg.max_bwd);
         for (int i = 0; i < PHASE_REQUESTS; i++)
            send_request(pick_input(surge_scale), pick_input(sb.yaw_limit()));
         req_if.valid <= 1'b0;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests over %0d register settings, %0d responses checked, %0d mismatches",
               requests_sent, settings_used, sb.checked, sb.mismatches);
      $display("covered zero and full-scale registers, mismatched reciprocal, stalls both ways");
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("differential_thrust_allocator_top verification clean");
      end else begin
         $display("differential_thrust_allocator_top verification failed");
      end
      $finish;
   end

endmodule
